// ----- design/raft_consensus_node_macros.svh -----
// Assertion helpers used by the top-level file of this design.
`ifndef RAFT_CONSENSUS_NODE_MACROS_SVH
`define RAFT_CONSENSUS_NODE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RCN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define RCN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/rcn_pkg.sv -----
`default_nettype none
package rcn_pkg;

    localparam int DEF_MAX_PEERS = 4;
    localparam int DEF_LOG_DEPTH = 1024;

    localparam logic [2:0] CMD_VOTE_REQ   = 3'd0;
    localparam logic [2:0] CMD_VOTE_REP   = 3'd1;
    localparam logic [2:0] CMD_APPEND_REQ = 3'd2;
    localparam logic [2:0] CMD_APPEND_REP = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;
    localparam logic [2:0] CMD_CLIENT     = 3'd5;

    localparam logic [1:0] KIND_VOTE_REP   = 2'd0;
    localparam logic [1:0] KIND_APPEND_REP = 2'd1;
    localparam logic [1:0] KIND_VOTE_BCAST = 2'd2;
    localparam logic [1:0] KIND_STATUS     = 2'd3;

    localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_LEADER    = 2'd2;

    localparam logic [1:0] CODE_OK         = 2'd0;
    localparam logic [1:0] CODE_NOT_LEADER = 2'd1;
    localparam logic [1:0] CODE_LOG_FULL   = 2'd2;

    localparam logic REG_NODE_ID    = 1'b0;
    localparam logic REG_PEER_COUNT = 1'b1;

    localparam logic [31:0] TERM_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        RD_A = 2'd0,
        RD_B = 2'd1,
        RD_C = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    latch_a;
        logic    exec;
        logic    maj_step;
        logic    commit_chk;
        logic    out_load;
        rd_sel_t rd_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_adv;
        logic maj_last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/raft_consensus_node.sv -----
`default_nettype none
// Channel   Handshake          Payload
// s_        s_valid/s_ready    cmd, terms, sender, log index/term, entry, commit, reply
// m_        m_valid/m_ready    kind, term, flag, index, log term, role, commit, code
// cfg_      cfg_we (no wait)   cfg_index, cfg_wdata
//
// One item at a time: accept, two log memory reads, execute, then result.
// Items that move the commit index by majority (append reply or client append as leader) add
// a walk over MAX_PEERS + 2 match values plus a memory read and check.
// Reset is synchronous, active low; the log memory is not cleared.
// A result waiting on m_ready holds the block in its final step; input stalls cost nothing.
module raft_consensus_node #(
    parameter int MAX_PEERS = rcn_pkg::DEF_MAX_PEERS,
    parameter int LOG_DEPTH = rcn_pkg::DEF_LOG_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [2:0]  cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_cmd,
    input  wire  [31:0] s_msg_term,
    input  wire  [2:0]  s_sender_id,
    input  wire  [10:0] s_log_index,
    input  wire  [31:0] s_log_term,
    input  wire         s_has_entry,
    input  wire  [31:0] s_entry_term,
    input  wire  [10:0] s_leader_commit,
    input  wire         s_success_in,
    input  wire  [10:0] s_reply_match,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_out_kind,
    output logic [31:0] m_out_term,
    output logic        m_out_flag,
    output logic [10:0] m_out_index,
    output logic [31:0] m_out_log_term,
    output logic [1:0]  m_role,
    output logic [10:0] m_commit_index,
    output logic [1:0]  m_out_code
);
    import rcn_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    rcn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (ctl_cmd),
        .stat    (dp_stat)
    );

    rcn_dp #(
        .MAX_PEERS (MAX_PEERS),
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_cmd           (s_cmd),
        .s_msg_term      (s_msg_term),
        .s_sender_id     (s_sender_id),
        .s_log_index     (s_log_index),
        .s_log_term      (s_log_term),
        .s_has_entry     (s_has_entry),
        .s_entry_term    (s_entry_term),
        .s_leader_commit (s_leader_commit),
        .s_success_in    (s_success_in),
        .s_reply_match   (s_reply_match),
        .cmd             (ctl_cmd),
        .stat            (dp_stat),
        .m_out_kind      (m_out_kind),
        .m_out_term      (m_out_term),
        .m_out_flag      (m_out_flag),
        .m_out_index     (m_out_index),
        .m_out_log_term  (m_out_log_term),
        .m_role          (m_role),
        .m_commit_index  (m_commit_index),
        .m_out_code      (m_out_code)
    );

`include "raft_consensus_node_macros.svh"

    // Every accepted transfer reaches the execute step by way of the two read states.
    `RCN_ASSERT(a_exec_after_accept, (s_valid && s_ready) |-> ##3 ctl_cmd.exec, "execute step missed")
    // The datapath never executes or loads a result while the port is open for input.
    `RCN_ASSERT(a_idle_quiet, s_ready |-> (!ctl_cmd.exec && !ctl_cmd.out_load), "work while idle")
    // No result is offered right after reset.
    `RCN_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

endmodule
`default_nettype wire

// ----- design/rcn_ctrl.sv -----
`default_nettype none
module rcn_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire                 m_ready,
    output logic                m_valid,
    output rcn_pkg::ctl_cmd_t   cmd,
    input  rcn_pkg::dp_stat_t   stat
);
    import rcn_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RDA  = 8'b0000_0010,
        ST_RDB  = 8'b0000_0100,
        ST_EXEC = 8'b0000_1000,
        ST_MAJ  = 8'b0001_0000,
        ST_CRD  = 8'b0010_0000,
        ST_CCHK = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_A;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) state_next = ST_RDA;
            end
            ST_RDA: begin
                cmd.rd_sel = RD_A;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                cmd.rd_sel  = RD_B;
                cmd.latch_a = 1'b1;
                state_next  = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.need_adv ? ST_MAJ : ST_DONE;
            end
            ST_MAJ: begin
                cmd.maj_step = 1'b1;
                if (stat.maj_last) state_next = ST_CRD;
            end
            ST_CRD: begin
                cmd.rd_sel = RD_C;
                state_next = ST_CCHK;
            end
            ST_CCHK: begin
                cmd.commit_chk = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                // The result register may still hold an earlier result.
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/rcn_dp.sv -----
`default_nettype none
module rcn_dp #(
    parameter int MAX_PEERS = rcn_pkg::DEF_MAX_PEERS,
    parameter int LOG_DEPTH = rcn_pkg::DEF_LOG_DEPTH
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_we,
    input  wire                cfg_index,
    input  wire  [2:0]         cfg_wdata,
    input  wire  [2:0]         s_cmd,
    input  wire  [31:0]        s_msg_term,
    input  wire  [2:0]         s_sender_id,
    input  wire  [10:0]        s_log_index,
    input  wire  [31:0]        s_log_term,
    input  wire                s_has_entry,
    input  wire  [31:0]        s_entry_term,
    input  wire  [10:0]        s_leader_commit,
    input  wire                s_success_in,
    input  wire  [10:0]        s_reply_match,
    input  rcn_pkg::ctl_cmd_t  cmd,
    output rcn_pkg::dp_stat_t  stat,
    output logic [1:0]         m_out_kind,
    output logic [31:0]        m_out_term,
    output logic               m_out_flag,
    output logic [10:0]        m_out_index,
    output logic [31:0]        m_out_log_term,
    output logic [1:0]         m_role,
    output logic [10:0]        m_commit_index,
    output logic [1:0]         m_out_code
);
    import rcn_pkg::*;

    localparam int LW  = $clog2(LOG_DEPTH + 1);
    localparam int XW  = ((LW > 11) ? LW : 11) + 1;
    localparam int AW  = $clog2(LOG_DEPTH);
    localparam int NW  = $clog2(LOG_DEPTH + 2);
    localparam int NP  = MAX_PEERS + 1;
    localparam int NV  = MAX_PEERS + 2;
    localparam int MIW = $clog2(NV);

    // Configuration and node state.
    logic [2:0]    node_id_reg, peer_count_reg;
    logic [1:0]    role_reg, role_next;
    logic [31:0]   term_reg, term_next;
    logic [2:0]    voted_reg, voted_next;
    logic [2:0]    votes_reg, votes_next;
    logic          hb_reg, hb_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] commit_reg, commit_next;
    logic [LW-1:0] match_reg [NP];
    logic [LW-1:0] match_next [NP];
    logic [NW-1:0] pnext_reg [NP];
    logic [NW-1:0] pnext_next [NP];

    // Captured item.
    logic [2:0]  cmd_in_reg;
    logic [31:0] mterm_reg;
    logic [2:0]  sender_reg;
    logic [10:0] lidx_reg;
    logic [31:0] lterm_reg;
    logic        has_e_reg;
    logic [31:0] eterm_reg;
    logic [10:0] lcommit_reg;
    logic        succ_reg;
    logic [10:0] rmatch_reg;

    // Log memory.
    logic [31:0]   mem [LOG_DEPTH];
    logic [31:0]   rd_data_reg, term_a_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;

    // Majority walk.
    logic [MIW-1:0] maj_idx_reg, maj_idx_next;
    logic [LW-1:0]  best_reg, best_next;

    // Per-item result.
    logic [1:0]  kind_reg, kind_next;
    logic        flag_reg, flag_next;
    logic [10:0] oidx_reg, oidx_next;
    logic [31:0] olterm_reg, olterm_next;
    logic [1:0]  code_reg, code_next;

    logic [3:0]    eff;
    logic [4:0]    need;
    logic [4:0]    win_votes;
    logic [NP-1:0] peer_inc;
    logic          sender_is_peer;
    logic [LW-1:0] vals [NV];
    logic [NV-1:0] val_inc;
    logic [4:0]    ge_count;
    logic [LW-1:0] cand;
    logic [XW-1:0] lidx_x, len_x, last_new;
    logic [31:0]   last_t;

    assign eff = ({1'b0, peer_count_reg} > 4'(MAX_PEERS)) ? 4'(MAX_PEERS)
                                                          : {1'b0, peer_count_reg};
    // Votes needed: floor((eff + 1) / 2) + 1; entries needed for a commit majority.
    assign win_votes = 5'(({1'b0, eff} + 5'd1) >> 1) + 5'd1;
    assign need      = {1'b0, eff} + 5'd1 - {2'b00, eff[3:1]};

    assign lidx_x = XW'(lidx_reg);
    assign len_x  = XW'(len_reg);
    assign last_t = (len_reg != '0) ? term_a_reg : 32'd0;
    assign last_new = lidx_x + XW'(has_e_reg);

    // Peers are the first eff identifiers counting up from one, skipping our own.
    always_comb begin
        logic [4:0] kk;
        logic [4:0] rank;
        logic       skip;
        for (int k = 1; k <= NP; k++) begin
            kk   = 5'(k);
            skip = (node_id_reg != 3'd0) && ({2'b00, node_id_reg} < kk);
            rank = kk - 5'd1 - {4'd0, skip};
            peer_inc[k-1] = ({2'b00, node_id_reg} != kk) && (rank < {1'b0, eff});
        end
    end

    always_comb begin
        sender_is_peer = 1'b0;
        for (int k = 1; k <= NP; k++) begin
            if ({2'b00, sender_reg} == 5'(k) && peer_inc[k-1]) sender_is_peer = 1'b1;
        end
    end

    always_comb begin
        vals[0]    = len_reg;
        val_inc[0] = 1'b1;
        for (int k = 1; k < NV; k++) begin
            vals[k]    = match_reg[k-1];
            val_inc[k] = peer_inc[k-1];
        end
    end

    assign cand = vals[maj_idx_reg];

    always_comb begin
        ge_count = '0;
        for (int k = 0; k < NV; k++) begin
            ge_count = ge_count + 5'(val_inc[k] && (vals[k] >= cand));
        end
    end

    assign stat.maj_last = (maj_idx_reg == MIW'(NV - 1));
    assign stat.need_adv = (role_reg == ROLE_LEADER)
                           && (((cmd_in_reg == CMD_APPEND_REP) && (mterm_reg <= term_reg)
                                && sender_is_peer && succ_reg)
                           || ((cmd_in_reg == CMD_CLIENT)
                               && (len_x < XW'(LOG_DEPTH))));

    always_comb begin
        unique case (cmd.rd_sel)
            RD_A:    rd_addr = (cmd_in_reg == CMD_APPEND_REQ) ? AW'(lidx_x - XW'(1))
                                                            : AW'(len_x - XW'(1));
            RD_B:    rd_addr = AW'(lidx_x);
            RD_C:    rd_addr = AW'(best_reg - LW'(1));
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        logic          ok;
        logic [2:0]    v1;
        logic [LW-1:0] m;
        logic [XW-1:0] c;
        role_next    = role_reg;
        term_next    = term_reg;
        voted_next   = voted_reg;
        votes_next   = votes_reg;
        hb_next      = hb_reg;
        len_next     = len_reg;
        commit_next  = commit_reg;
        maj_idx_next = maj_idx_reg;
        best_next    = best_reg;
        kind_next    = kind_reg;
        flag_next    = flag_reg;
        oidx_next    = oidx_reg;
        olterm_next  = olterm_reg;
        code_next    = code_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(lidx_x);
        wr_data      = eterm_reg;
        ok           = 1'b1;
        v1           = 3'd0;
        m            = '0;
        c            = '0;
        for (int k = 0; k < NP; k++) begin
            match_next[k] = match_reg[k];
            pnext_next[k] = pnext_reg[k];
        end

        if (cmd.exec) begin
            kind_next    = KIND_STATUS;
            flag_next    = 1'b0;
            oidx_next    = '0;
            olterm_next  = '0;
            code_next    = CODE_OK;
            maj_idx_next = '0;
            best_next    = '0;
            unique case (cmd_in_reg)
                CMD_VOTE_REQ: begin
                    kind_next = KIND_VOTE_REP;
                    hb_next   = 1'b1;
                    if (mterm_reg > term_reg) begin
                        term_next  = mterm_reg;
                        role_next  = ROLE_FOLLOWER;
                        voted_next = 3'd0;
                    end
                    if (mterm_reg == term_next
                        && (voted_next == 3'd0 || voted_next == sender_reg)
                        && (lterm_reg > last_t || (lterm_reg == last_t && lidx_x >= len_x))) begin
                        voted_next = sender_reg;
                        flag_next  = 1'b1;
                    end
                end
                CMD_VOTE_REP: begin
                    if (mterm_reg > term_reg) begin
                        term_next  = mterm_reg;
                        role_next  = ROLE_FOLLOWER;
                        voted_next = 3'd0;
                    end else if (role_reg == ROLE_CANDIDATE && succ_reg
                                 && mterm_reg == term_reg) begin
                        v1         = (votes_reg == 3'd7) ? 3'd7 : votes_reg + 3'd1;
                        votes_next = v1;
                        if ({2'b00, v1} >= win_votes) begin
                            role_next = ROLE_LEADER;
                            for (int k = 0; k < NP; k++) begin
                                match_next[k] = '0;
                                pnext_next[k] = NW'(len_reg) + NW'(1);
                            end
                        end
                    end
                end
                CMD_APPEND_REQ: begin
                    kind_next = KIND_APPEND_REP;
                    if (mterm_reg >= term_reg) begin
                        if (mterm_reg > term_reg) begin
                            term_next  = mterm_reg;
                            voted_next = 3'd0;
                        end
                        role_next = ROLE_FOLLOWER;
                        hb_next   = 1'b1;
                        if (lidx_reg != '0 && (lidx_x > len_x || term_a_reg != lterm_reg))
                            ok = 1'b0;
                        if (ok && has_e_reg) begin
                            // A matching entry already in place is kept as it is.
                            if (len_x > lidx_x) begin
                                if (rd_data_reg != eterm_reg) begin
                                    wr_en    = 1'b1;
                                    len_next = LW'(lidx_x + XW'(1));
                                end
                            end else if (len_x >= XW'(LOG_DEPTH)) begin
                                ok        = 1'b0;
                                code_next = CODE_LOG_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                len_next = len_reg + LW'(1);
                            end
                        end
                        if (ok) begin
                            if (XW'(lcommit_reg) > XW'(commit_reg)) begin
                                c = (XW'(lcommit_reg) < last_new) ? XW'(lcommit_reg) : last_new;
                                if (c > XW'(commit_reg)) commit_next = LW'(c);
                            end
                            flag_next = 1'b1;
                            oidx_next = 11'(last_new);
                        end
                    end
                end
                CMD_APPEND_REP: begin
                    if (mterm_reg > term_reg) begin
                        term_next  = mterm_reg;
                        role_next  = ROLE_FOLLOWER;
                        voted_next = 3'd0;
                    end else if (role_reg == ROLE_LEADER && sender_is_peer) begin
                        m = (XW'(rmatch_reg) > len_x) ? len_reg : LW'(rmatch_reg);
                        for (int k = 0; k < NP; k++) begin
                            if ({2'b00, sender_reg} == 5'(k + 1)) begin
                                if (succ_reg) begin
                                    match_next[k] = m;
                                    pnext_next[k] = NW'(m) + NW'(1);
                                end else if (pnext_reg[k] > NW'(1)) begin
                                    pnext_next[k] = pnext_reg[k] - NW'(1);
                                end else begin
                                    pnext_next[k] = NW'(1);
                                end
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (role_reg != ROLE_LEADER) begin
                        if (hb_reg) begin
                            hb_next = 1'b0;
                        end else begin
                            if (term_reg != TERM_MAX) term_next = term_reg + 32'd1;
                            role_next   = ROLE_CANDIDATE;
                            votes_next  = 3'd1;
                            voted_next  = node_id_reg;
                            kind_next   = KIND_VOTE_BCAST;
                            oidx_next   = 11'(len_reg);
                            olterm_next = last_t;
                            // A node without peers wins its own election at once.
                            if (5'd1 >= win_votes) begin
                                role_next = ROLE_LEADER;
                                for (int k = 0; k < NP; k++) begin
                                    match_next[k] = '0;
                                    pnext_next[k] = NW'(len_reg) + NW'(1);
                                end
                            end
                        end
                    end
                end
                CMD_CLIENT: begin
                    if (role_reg != ROLE_LEADER) begin
                        code_next = CODE_NOT_LEADER;
                    end else if (len_x >= XW'(LOG_DEPTH)) begin
                        code_next = CODE_LOG_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = AW'(len_x);
                        wr_data   = term_reg;
                        len_next  = len_reg + LW'(1);
                        flag_next = 1'b1;
                        oidx_next = 11'(len_x + XW'(1));
                    end
                end
                default: ;
            endcase
        end

        if (cmd.maj_step) begin
            // Highest value that a strict majority of the cluster has reached.
            if (val_inc[maj_idx_reg] && ge_count >= need && cand > best_reg) best_next = cand;
            maj_idx_next = maj_idx_reg + MIW'(1);
        end

        if (cmd.commit_chk) begin
            if (best_reg > commit_reg && best_reg <= len_reg && best_reg != '0
                && rd_data_reg == term_reg)
                commit_next = best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= 3'd1;
            peer_count_reg <= 3'd0;
            role_reg       <= ROLE_FOLLOWER;
            term_reg       <= '0;
            voted_reg      <= '0;
            votes_reg      <= '0;
            hb_reg         <= 1'b0;
            len_reg        <= '0;
            commit_reg     <= '0;
            maj_idx_reg    <= '0;
            best_reg       <= '0;
            for (int k = 0; k < NP; k++) begin
                match_reg[k] <= '0;
                pnext_reg[k] <= NW'(1);
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_NODE_ID) node_id_reg <= cfg_wdata;
                if (cfg_index == REG_PEER_COUNT) peer_count_reg <= cfg_wdata;
            end
            role_reg    <= role_next;
            term_reg    <= term_next;
            voted_reg   <= voted_next;
            votes_reg   <= votes_next;
            hb_reg      <= hb_next;
            len_reg     <= len_next;
            commit_reg  <= commit_next;
            maj_idx_reg <= maj_idx_next;
            best_reg    <= best_next;
            for (int k = 0; k < NP; k++) begin
                match_reg[k] <= match_next[k];
                pnext_reg[k] <= pnext_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_in_reg  <= s_cmd;
            mterm_reg   <= s_msg_term;
            sender_reg  <= s_sender_id;
            lidx_reg    <= s_log_index;
            lterm_reg   <= s_log_term;
            has_e_reg   <= s_has_entry;
            eterm_reg   <= s_entry_term;
            lcommit_reg <= s_leader_commit;
            succ_reg    <= s_success_in;
            rmatch_reg  <= s_reply_match;
        end
        if (cmd.latch_a) term_a_reg <= rd_data_reg;
        kind_reg   <= kind_next;
        flag_reg   <= flag_next;
        oidx_reg   <= oidx_next;
        olterm_reg <= olterm_next;
        code_reg   <= code_next;
        if (cmd.out_load) begin
            m_out_kind     <= kind_reg;
            m_out_term     <= term_reg;
            m_out_flag     <= flag_reg;
            m_out_index    <= oidx_reg;
            m_out_log_term <= olterm_reg;
            m_role         <= role_reg;
            m_commit_index <= 11'(commit_reg);
            m_out_code     <= code_reg;
        end
    end

endmodule
`default_nettype wire

// ----- dv/raft_consensus_node_test.sv -----
`timescale 1ns / 100ps

module raft_consensus_node_test;
    import rcn_pkg::*;

    localparam int PEERS = DEF_MAX_PEERS;
    localparam int DEPTH = DEF_LOG_DEPTH;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] msg_term;
        logic [2:0]  sender_id;
        logic [10:0] log_index;
        logic [31:0] log_term;
        logic        has_entry;
        logic [31:0] entry_term;
        logic [10:0] leader_commit;
        logic        success_in;
        logic [10:0] reply_match;
    } raft_msg_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] term;
        logic        flag;
        logic [10:0] index;
        logic [31:0] log_term;
        logic [1:0]  role;
        logic [10:0] commit;
        logic [1:0]  code;
    } raft_reply_t;

    // Mirror of the node state; predicts one reply for each accepted message.
    class raft_node_scoreboard;
        logic [2:0]  node_id = 3'd1;
        logic [2:0]  peer_count = 3'd0;
        logic [1:0]  role = ROLE_FOLLOWER;
        logic [31:0] term = 0;
        logic [2:0]  voted = 0;
        int          votes = 0;
        bit          hb_seen = 0;
        logic [31:0] log_terms [DEPTH];
        int          log_len = 0;
        int          committed = 0;
        int          pmatch [PEERS + 1];
        int          pnext [PEERS + 1];
        raft_reply_t replies_due [$];
        int          errors = 0;

        function new();
            foreach (log_terms[k]) log_terms[k] = 0;
            foreach (pmatch[k]) begin
                pmatch[k] = 0;
                pnext[k] = 1;
            end
        endfunction

        function int eff_peers();
            return (peer_count > PEERS) ? PEERS : peer_count;
        endfunction

        function bit is_peer(int id);
            int n;
            n = 0;
            for (int k = 1; k <= PEERS + 1 && n < eff_peers(); k++) begin
                if (k == node_id) continue;
                if (k == id) return 1;
                n++;
            end
            return 0;
        endfunction

        function logic [31:0] last_term();
            return log_len ? log_terms[(log_len - 1) % DEPTH] : 32'd0;
        endfunction

        function void step_down(logic [31:0] t);
            term = t;
            role = ROLE_FOLLOWER;
            voted = 0;
        endfunction

        function void become_leader();
            role = ROLE_LEADER;
            foreach (pmatch[k]) begin
                pmatch[k] = 0;
                pnext[k] = log_len + 1;
            end
        endfunction

        function bit majority(int v);
            return v >= (eff_peers() + 1) / 2 + 1;
        endfunction

        // Highest index held by a strict majority, counting our own log.
        function void advance_commit();
            int vals [$];
            int cand;
            vals.push_back(log_len);
            for (int k = 1; k <= PEERS + 1 && vals.size() < eff_peers() + 1; k++) begin
                if (k == node_id) continue;
                vals.push_back(pmatch[k - 1]);
            end
            vals.sort();
            cand = vals[(vals.size() - 1) / 2];
            if (cand > committed && cand <= log_len && cand > 0 &&
                log_terms[(cand - 1) % DEPTH] == term)
                committed = cand;
        endfunction

        function void note_input(raft_msg_t m);
            raft_reply_t r;
            bit ok;
            int last_new, c, s, mt;
            r = '{kind: KIND_STATUS, default: 0};
            case (m.cmd)
                CMD_VOTE_REQ: begin
                    r.kind = KIND_VOTE_REP;
                    hb_seen = 1;
                    if (m.msg_term > term) step_down(m.msg_term);
                    if (m.msg_term == term && (voted == 0 || voted == m.sender_id)) begin
                        if (m.log_term > last_term() ||
                            (m.log_term == last_term() && m.log_index >= log_len)) begin
                            voted = m.sender_id;
                            r.flag = 1;
                        end
                    end
                end
                CMD_VOTE_REP: begin
                    if (m.msg_term > term) step_down(m.msg_term);
                    else if (role == ROLE_CANDIDATE && m.success_in && m.msg_term == term) begin
                        if (votes < 7) votes++;
                        if (majority(votes)) become_leader();
                    end
                end
                CMD_APPEND_REQ: begin
                    r.kind = KIND_APPEND_REP;
                    if (m.msg_term >= term) begin
                        ok = 1;
                        if (m.msg_term > term) step_down(m.msg_term);
                        else role = ROLE_FOLLOWER;
                        hb_seen = 1;
                        if (m.log_index > 0 && (m.log_index > log_len ||
                            log_terms[(m.log_index - 1) % DEPTH] != m.log_term))
                            ok = 0;
                        if (ok && m.has_entry) begin
                            if (log_len > m.log_index) begin
                                if (log_terms[m.log_index % DEPTH] != m.entry_term) begin
                                    log_terms[m.log_index % DEPTH] = m.entry_term;
                                    log_len = m.log_index + 1;
                                end
                            end else if (log_len >= DEPTH) begin
                                ok = 0;
                                r.code = CODE_LOG_FULL;
                            end else begin
                                log_terms[log_len] = m.entry_term;
                                log_len++;
                            end
                        end
                        if (ok) begin
                            last_new = m.log_index + m.has_entry;
                            if (m.leader_commit > committed) begin
                                c = (m.leader_commit < last_new) ? m.leader_commit : last_new;
                                if (c > committed) committed = c;
                            end
                            r.flag = 1;
                            r.index = last_new[10:0];
                        end
                    end
                end
                CMD_APPEND_REP: begin
                    if (m.msg_term > term) step_down(m.msg_term);
                    else if (role == ROLE_LEADER && is_peer(m.sender_id)) begin
                        s = m.sender_id - 1;
                        if (m.success_in) begin
                            mt = (m.reply_match > log_len) ? log_len : m.reply_match;
                            pmatch[s] = mt;
                            pnext[s] = mt + 1;
                            advance_commit();
                        end else if (pnext[s] > 1) pnext[s]--;
                        else pnext[s] = 1;
                    end
                end
                CMD_TICK: begin
                    if (role != ROLE_LEADER) begin
                        if (hb_seen) hb_seen = 0;
                        else begin
                            if (term != TERM_MAX) term++;
                            role = ROLE_CANDIDATE;
                            votes = 1;
                            voted = node_id;
                            r.kind = KIND_VOTE_BCAST;
                            r.index = log_len[10:0];
                            r.log_term = last_term();
                            if (majority(votes)) become_leader();
                        end
                    end
                end
                CMD_CLIENT: begin
                    if (role != ROLE_LEADER) r.code = CODE_NOT_LEADER;
                    else if (log_len >= DEPTH) r.code = CODE_LOG_FULL;
                    else begin
                        log_terms[log_len] = term;
                        log_len++;
                        r.flag = 1;
                        r.index = log_len[10:0];
                        advance_commit();
                    end
                end
                default: ;
            endcase
            r.term = term;
            r.role = role;
            r.commit = committed[10:0];
            replies_due.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(raft_reply_t a);
            raft_reply_t e;
            if (replies_due.size() == 0) begin
                $error("reply transfer with no reply expected");
                errors++;
                return;
            end
            e = replies_due.pop_front();
            cmp("out_kind", e.kind, a.kind);
            cmp("out_term", e.term, a.term);
            cmp("out_flag", e.flag, a.flag);
            cmp("out_index", e.index, a.index);
            cmp("out_log_term", e.log_term, a.log_term);
            cmp("role", e.role, a.role);
            cmp("commit_index", e.commit, a.commit);
            cmp("out_code", e.code, a.code);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [2:0]  cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_cmd = 0;
    logic [31:0] s_msg_term = 0;
    logic [2:0]  s_sender_id = 0;
    logic [10:0] s_log_index = 0;
    logic [31:0] s_log_term = 0;
    logic        s_has_entry = 0;
    logic [31:0] s_entry_term = 0;
    logic [10:0] s_leader_commit = 0;
    logic        s_success_in = 0;
    logic [10:0] s_reply_match = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_out_kind;
    logic [31:0] m_out_term;
    logic        m_out_flag;
    logic [10:0] m_out_index;
    logic [31:0] m_out_log_term;
    logic [1:0]  m_role;
    logic [10:0] m_commit_index;
    logic [1:0]  m_out_code;

    raft_node_scoreboard node_sb = new();
    int  burst_left = 0;
    bit  holdoff_req = 0;
    bit  stim_done = 0;

    always #4 aclk = ~aclk;

    raft_consensus_node dut (.*);

    // Reply side: rotating stall patterns plus one long hold-off on request.
    initial begin
        int cyc, hold;
        cyc = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                node_sb.check_result('{m_out_kind, m_out_term, m_out_flag, m_out_index,
                                       m_out_log_term, m_role, m_commit_index, m_out_code});
            cyc++;
            if (holdoff_req && hold == 0) begin
                hold = 300;
                holdoff_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else begin
                case ((cyc / 97) % 4)
                    0: m_ready <= 1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc % 7) < 5);
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("raft_consensus_node_test NOT OK");
        $finish;
    end

    function logic [31:0] sat_add(logic [31:0] a, int unsigned d);
        return (TERM_MAX - a < d) ? TERM_MAX : a + d;
    endfunction

    function logic [31:0] pick_term();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return node_sb.term;
        if (r < 85) return sat_add(node_sb.term, 1);
        if (r < 95) return (node_sb.term > 3) ? node_sb.term - $urandom_range(1, 3) : 32'd0;
        if (r < 99) return sat_add(node_sb.term, $urandom_range(2, 1000));
        return $urandom;
    endfunction

    function logic [2:0] pick_peer();
        logic [2:0] id;
        if (node_sb.eff_peers() == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 7);
        do id = $urandom_range(1, PEERS + 1); while (!node_sb.is_peer(id));
        return id;
    endfunction

    function raft_msg_t gen_msg();
        raft_msg_t m;
        int r, len;
        m.cmd = $urandom_range(0, 7);
        m.msg_term = pick_term();
        m.sender_id = $urandom_range(0, 7);
        m.log_index = $urandom_range(0, 2047);
        m.log_term = $urandom;
        m.has_entry = $urandom_range(0, 1);
        m.entry_term = $urandom;
        m.leader_commit = $urandom_range(0, 2047);
        m.success_in = $urandom_range(0, 1);
        m.reply_match = $urandom_range(0, 2047);
        if ($urandom_range(0, 99) < 12) return m;
        len = node_sb.log_len;
        r = $urandom_range(0, 99);
        case (node_sb.role)
            ROLE_LEADER: m.cmd = (r < 40) ? CMD_CLIENT : (r < 75) ? CMD_APPEND_REP :
                                 (r < 82) ? CMD_VOTE_REP : (r < 88) ? CMD_TICK :
                                 (r < 94) ? CMD_VOTE_REQ : CMD_APPEND_REQ;
            ROLE_CANDIDATE: m.cmd = (r < 55) ? CMD_VOTE_REP : (r < 70) ? CMD_TICK :
                                    (r < 85) ? CMD_APPEND_REQ : CMD_VOTE_REQ;
            default: m.cmd = (r < 35) ? CMD_TICK : (r < 75) ? CMD_APPEND_REQ :
                             (r < 90) ? CMD_VOTE_REQ : CMD_APPEND_REP;
        endcase
        m.sender_id = pick_peer();
        case (m.cmd)
            CMD_VOTE_REQ: begin
                m.log_index = (len + $urandom_range(0, 2) > 0) ? len + $urandom_range(0, 2) - 1 : 0;
                m.log_term = node_sb.last_term() + $urandom_range(0, 2) - 1;
            end
            CMD_VOTE_REP: begin
                m.msg_term = ($urandom_range(0, 4) == 0) ? pick_term() : node_sb.term;
                m.success_in = ($urandom_range(0, 5) != 0);
            end
            CMD_APPEND_REQ: begin
                m.log_index = ($urandom_range(0, 9) < 7) ? len : $urandom_range(0, len);
                m.log_term = m.log_index ? node_sb.log_terms[m.log_index - 1] : 32'd0;
                if ($urandom_range(0, 9) == 0) m.log_term ^= 32'd1;
                m.has_entry = ($urandom_range(0, 4) != 0);
                m.entry_term = node_sb.term;
                if (m.log_index < len && $urandom_range(0, 1))
                    m.entry_term = node_sb.log_terms[m.log_index] ^ $urandom_range(0, 1);
                m.leader_commit = $urandom_range(0, len + 1);
            end
            CMD_APPEND_REP: begin
                m.msg_term = ($urandom_range(0, 4) == 0) ? pick_term() : node_sb.term;
                m.success_in = ($urandom_range(0, 4) != 0);
                m.reply_match = $urandom_range(0, len + 2);
            end
            default: ;
        endcase
        return m;
    endfunction

    function raft_msg_t mk(logic [2:0] cmd, logic [31:0] mterm, logic [2:0] sender,
                           logic [10:0] lidx, logic [31:0] lterm, logic has_e,
                           logic [31:0] eterm, logic [10:0] lcommit, logic succ,
                           logic [10:0] rmatch);
        return '{cmd, mterm, sender, lidx, lterm, has_e, eterm, lcommit, succ, rmatch};
    endfunction

    task automatic send_msg(raft_msg_t m);
        s_cmd <= m.cmd;
        s_msg_term <= m.msg_term;
        s_sender_id <= m.sender_id;
        s_log_index <= m.log_index;
        s_log_term <= m.log_term;
        s_has_entry <= m.has_entry;
        s_entry_term <= m.entry_term;
        s_leader_commit <= m.leader_commit;
        s_success_in <= m.success_in;
        s_reply_match <= m.reply_match;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        node_sb.note_input(m);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            // Long bursts without gaps every so often.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (node_sb.replies_due.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_config(logic [2:0] id, logic [2:0] peers);
        drain();
        cfg_we <= 1;
        cfg_index <= REG_NODE_ID;
        cfg_wdata <= id;
        @(posedge aclk);
        cfg_index <= REG_PEER_COUNT;
        cfg_wdata <= peers;
        @(posedge aclk);
        cfg_we <= 0;
        node_sb.node_id = id;
        node_sb.peer_count = peers;
    endtask

    initial begin
        logic [2:0] cfg_ids [7] = '{3'd5, 3'd3, 3'd2, 3'd0, 3'd7, 3'd4, 3'd1};
        logic [2:0] cfg_pcs [7] = '{3'd4, 3'd2, 3'd1, 3'd7, 3'd5, 3'd3, 3'd4};
        logic [31:0] t;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        write_config(3'd1, 3'd0);

        // Directed: grants, rejections, single-node election, commits, unknown codes.
        send_msg(mk(CMD_VOTE_REQ, 0, 2, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_VOTE_REQ, 0, 3, 11'h7FF, TERM_MAX, 1, TERM_MAX, 11'h7FF, 1, 11'h7FF));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 0, 0, 1, 1, 1, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 1, 1, 1, 1, 11'h7FF, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 1, 1, 1, 1, 2, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 5, 1, 1, 1, 0, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 1, 7, 1, 1, 0, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 1, 2, 1, 1, 1, 3, 0, 0, 0));
        send_msg(mk(CMD_VOTE_REP, 1, 2, 0, 0, 0, 0, 0, 1, 0));
        send_msg(mk(CMD_APPEND_REP, 1, 2, 0, 0, 0, 0, 0, 1, 2));
        send_msg(mk(CMD_CLIENT, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_CLIENT, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_CLIENT, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_APPEND_REP, 2, 0, 0, 0, 0, 0, 0, 1, 11'h7FF));
        send_msg(mk(CMD_TICK, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(3'd6, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(3'd7, TERM_MAX, 7, 11'h7FF, TERM_MAX, 1, TERM_MAX, 11'h7FF, 1, 11'h7FF));
        send_msg(mk(CMD_VOTE_REQ, 1, 4, 9, 9, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_APPEND_REQ, 2, 4, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_CLIENT, 2, 0, 0, 0, 0, 0, 0, 0, 0));

        for (int p = 0; p < 7; p++) begin
            write_config(cfg_ids[p], cfg_pcs[p]);
            for (int i = 0; i < 120; i++) begin
                if (i == 60) drain();
                // The reply side stalls for a long stretch while messages keep coming.
                if (p == 0 && i == 5) holdoff_req = 1;
                send_msg(gen_msg());
            end
            if (p == 3) begin
                // Fill the log as a follower until appends run out of room.
                write_config(3'd2, 3'd0);
                t = node_sb.term;
                repeat (DEPTH + 2 - node_sb.log_len)
                    send_msg(mk(CMD_APPEND_REQ, t, 1, node_sb.log_len[10:0],
                                node_sb.last_term(), 1, t, $urandom_range(0, 2047), 0, 0));
                send_msg(mk(CMD_TICK, t, 0, 0, 0, 0, 0, 0, 0, 0));
                send_msg(mk(CMD_TICK, t, 0, 0, 0, 0, 0, 0, 0, 0));
                send_msg(mk(CMD_CLIENT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
                t = node_sb.term;
                send_msg(mk(CMD_APPEND_REQ, t, 1, 0, 0, 1, ~node_sb.log_terms[0], 0, 0, 0));
            end
        end

        // Terms at the top of the range: an election there keeps the term.
        send_msg(mk(CMD_APPEND_REQ, TERM_MAX, 1, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_msg(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        drain();
        if (node_sb.errors == 0)
            $display("raft_consensus_node_test OK");
        else
            $display("raft_consensus_node_test NOT OK");
        $finish;
    end

endmodule
